// ----- hdl/multi_queue_ring_buffer_macros.svh -----
// Assertion helpers for the multi-queue ring buffer.
// Every property is sampled on clk and is switched off while rst_n is low.
`ifndef MULTI_QUEUE_RING_BUFFER_MACROS_SVH
`define MULTI_QUEUE_RING_BUFFER_MACROS_SVH

`ifndef SYNTH

`define MQRB_ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("same-cycle check failed");

`define MQRB_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("next-cycle check failed");

`else

`define MQRB_ASSERT_SAME(label, pre, post)

`define MQRB_ASSERT_NEXT(label, pre, post)

`endif

`endif

// ----- hdl/mqrb_pkg.sv -----
`timescale 1ns / 1ps

package mqrb_pkg;

  localparam int NUM_QUEUES_DEF  = 8;
  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int FUNC_W  = 2;
  localparam int QIDX_W  = 4;
  localparam int WORD_W  = 32;
  localparam int STAT_W  = 2;

  typedef enum logic [FUNC_W-1:0] {
    OP_INIT  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_RSVD  = 2'd3
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    func_t               func;
    logic [QIDX_W-1:0]   queue_index;
    logic [WORD_W-1:0]   write_data;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [WORD_W-1:0]   read_data;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_RESP = 2'd2
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load_out;
  } ctrl_cmd_t;

endpackage

// ----- hdl/mqrb_ram.sv -----
`timescale 1ns / 1ps

module mqrb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/mqrb_ctrl.sv -----
`timescale 1ns / 1ps
`include "multi_queue_ring_buffer_macros.svh"

module mqrb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output mqrb_pkg::ctrl_cmd_t cmd
);

  mqrb_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;

  // The result register can take a new item if it is empty or is being emptied now.
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mqrb_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = mqrb_pkg::S_EXEC;
        end
      end
      mqrb_pkg::S_EXEC: begin
        state_nxt = mqrb_pkg::S_RESP;
      end
      mqrb_pkg::S_RESP: begin
        if (slot_free) begin
          state_nxt = mqrb_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mqrb_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.capture  = 1'b0;
    cmd.exec     = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state_r)
      mqrb_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      mqrb_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
      end
      mqrb_pkg::S_RESP: begin
        cmd.load_out = slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mqrb_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `MQRB_ASSERT_NEXT(a_accept_runs, in_valid && in_ready, state_r == mqrb_pkg::S_EXEC)
  `MQRB_ASSERT_NEXT(a_exec_one_cycle, state_r == mqrb_pkg::S_EXEC,
                    state_r == mqrb_pkg::S_RESP && !in_ready)
  `MQRB_ASSERT_NEXT(a_resp_delivers, state_r == mqrb_pkg::S_RESP && slot_free,
                    state_r == mqrb_pkg::S_IDLE && out_valid_r)
  `MQRB_ASSERT_SAME(a_no_accept_busy, state_r != mqrb_pkg::S_IDLE, !in_ready)

endmodule

// ----- hdl/mqrb_dpath.sv -----
`timescale 1ns / 1ps

module mqrb_dpath #(
  parameter int NUM_QUEUES  = mqrb_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = mqrb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mqrb_pkg::ctrl_cmd_t  cmd,
  input  mqrb_pkg::in_item_t   in_item,
  output mqrb_pkg::out_item_t  out_item
);

  localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOTS = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  mqrb_pkg::in_item_t  item_r;
  mqrb_pkg::out_item_t out_r;

  logic [PTR_W-1:0] head_r [NUM_QUEUES];
  logic [PTR_W-1:0] tail_r [NUM_QUEUES];
  logic [CNT_W-1:0] fill_r [NUM_QUEUES];

  mqrb_pkg::status_t status_r, status_nxt;
  logic              rd_ok_r, rd_ok_nxt;

  logic [QW-1:0]     q;
  logic              bad_idx;
  logic [PTR_W-1:0]  head, tail, ptr;
  logic [CNT_W-1:0]  fill;
  logic              do_init, do_read, do_write;
  logic [AW-1:0]     addr;
  logic [mqrb_pkg::WORD_W-1:0] ram_rdata;

  assign q    = item_r.queue_index[QW-1:0];
  assign head = head_r[q];
  assign tail = tail_r[q];
  assign fill = fill_r[q];

  // The unused operation code is ignored before the index is looked at.
  assign bad_idx = (item_r.func != mqrb_pkg::OP_RSVD) &&
                   (item_r.queue_index >= mqrb_pkg::QIDX_W'(NUM_QUEUES));

  always_comb begin
    status_nxt = mqrb_pkg::ST_OK;
    rd_ok_nxt  = 1'b0;
    do_init    = 1'b0;
    do_read    = 1'b0;
    do_write   = 1'b0;
    if (bad_idx) begin
      status_nxt = mqrb_pkg::ST_BAD_INDEX;
    end else begin
      unique case (item_r.func)
        mqrb_pkg::OP_INIT: begin
          do_init = 1'b1;
        end
        mqrb_pkg::OP_READ: begin
          if (fill == '0) begin
            status_nxt = mqrb_pkg::ST_EMPTY;
          end else begin
            do_read   = 1'b1;
            rd_ok_nxt = 1'b1;
          end
        end
        mqrb_pkg::OP_WRITE: begin
          if (fill == CNT_W'(QUEUE_DEPTH)) begin
            status_nxt = mqrb_pkg::ST_FULL;
          end else begin
            do_write = 1'b1;
          end
        end
        default: begin
          status_nxt = mqrb_pkg::ST_OK;
        end
      endcase
    end
  end

  assign ptr  = do_read ? head : tail;
  assign addr = AW'(q) * AW'(QUEUE_DEPTH) + AW'(ptr);

  mqrb_ram #(
    .WIDTH (mqrb_pkg::WORD_W),
    .DEPTH (SLOTS)
  ) u_store (
    .clk   (clk),
    .we    (cmd.exec && do_write),
    .re    (cmd.exec && do_read),
    .addr  (addr),
    .wdata (item_r.write_data),
    .rdata (ram_rdata)
  );

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    advance = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        fill_r[i] <= '0;
      end
    end else if (cmd.exec) begin
      if (do_init) begin
        head_r[q] <= '0;
        tail_r[q] <= '0;
        fill_r[q] <= '0;
      end else if (do_read) begin
        head_r[q] <= advance(head);
        fill_r[q] <= fill - 1'b1;
      end else if (do_write) begin
        tail_r[q] <= advance(tail);
        fill_r[q] <= fill + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_item;
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
      rd_ok_r  <= rd_ok_nxt;
    end
    if (cmd.load_out) begin
      out_r.status    <= status_r;
      out_r.read_data <= rd_ok_r ? ram_rdata : '0;
    end
  end

  assign out_item = out_r;

endmodule

// ----- hdl/multi_queue_ring_buffer.sv -----
`timescale 1ns / 1ps
// Bank of NUM_QUEUES circular word queues held in one shared word store.
// Input channel (in_valid, in_ready, in_item): one operation per item, init,
// read or write (the unused code only returns ST_OK), on the queue named by
// queue_index. Result channel (out_valid, out_ready, out_item): exactly one
// result per item, carrying a status and, for a successful read, the word
// taken from the queue head. An accepted item is registered, executed, then
// its result is loaded into the output register once that register is free;
// no new item is taken before that. The execute step looks up the queue
// pointers; the registered store read port passes the word on for the result.
// A new item is taken while an earlier result still waits in the output
// register. If the receiver stalls, the block holds the next result
// internally and stops taking items until the output register is free.
// Reset (rst_n low at a clock edge) empties every queue at once; no sweep
// of the store is needed, and words written before are not read again.

module multi_queue_ring_buffer #(
  parameter int NUM_QUEUES  = mqrb_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = mqrb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mqrb_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output mqrb_pkg::out_item_t out_item
);

  mqrb_pkg::ctrl_cmd_t cmd;

  mqrb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  mqrb_dpath #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .out_item (out_item)
  );

endmodule

// ----- tb/tb_multi_queue_ring_buffer.sv -----
`timescale 1ns / 1ps

module tb_multi_queue_ring_buffer;

  localparam int NUM_Q          = mqrb_pkg::NUM_QUEUES_DEF;
  localparam int DEPTH          = mqrb_pkg::QUEUE_DEPTH_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 12;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  mqrb_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  mqrb_pkg::out_item_t out_item;

  // Own copy of the queue state, advanced as each item is accepted.
  logic [mqrb_pkg::WORD_W-1:0] word_mem [NUM_Q*DEPTH];
  int unsigned                 q_head [NUM_Q];
  int unsigned                 q_tail [NUM_Q];
  int unsigned                 q_fill [NUM_Q];

  mqrb_pkg::out_item_t expected_results [$];
  int                  mismatches = 0;
  int                  items_sent = 0;
  int                  in_gap_odds = 0;
  int                  out_stall_odds = 0;
  int                  stall_left = 0;
  int                  quiet_cycles = 0;

  multi_queue_ring_buffer #(
    .NUM_QUEUES (NUM_Q),
    .QUEUE_DEPTH(DEPTH)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic mqrb_pkg::in_item_t make_item(mqrb_pkg::func_t f,
                                                   logic [mqrb_pkg::QIDX_W-1:0] q,
                                                   logic [mqrb_pkg::WORD_W-1:0] d);
    mqrb_pkg::in_item_t it;
    it.func        = f;
    it.queue_index = q;
    it.write_data  = d;
    return it;
  endfunction

  function automatic mqrb_pkg::out_item_t predict_result(mqrb_pkg::in_item_t it);
    mqrb_pkg::out_item_t r;
    int unsigned         q;
    r.status    = mqrb_pkg::ST_OK;
    r.read_data = '0;
    q = 32'(it.queue_index);
    if (it.func != mqrb_pkg::OP_RSVD) begin
      if (q >= NUM_Q) begin
        r.status = mqrb_pkg::ST_BAD_INDEX;
      end else if (it.func == mqrb_pkg::OP_INIT) begin
        q_head[q] = 0;
        q_tail[q] = 0;
        q_fill[q] = 0;
      end else if (it.func == mqrb_pkg::OP_READ) begin
        if (q_fill[q] == 0) begin
          r.status = mqrb_pkg::ST_EMPTY;
        end else begin
          r.read_data = word_mem[q*DEPTH + q_head[q]];
          q_head[q]   = (q_head[q] + 1 == DEPTH) ? 0 : q_head[q] + 1;
          q_fill[q]   = q_fill[q] - 1;
        end
      end else begin
        if (q_fill[q] >= DEPTH) begin
          r.status = mqrb_pkg::ST_FULL;
        end else begin
          word_mem[q*DEPTH + q_tail[q]] = it.write_data;
          q_tail[q] = (q_tail[q] + 1 == DEPTH) ? 0 : q_tail[q] + 1;
          q_fill[q] = q_fill[q] + 1;
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic check_result(mqrb_pkg::out_item_t got);
    mqrb_pkg::out_item_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result %s/%h with no item outstanding",
                                got.status.name(), got.read_data));
    end else begin
      want = expected_results.pop_front();
      if (got.status !== want.status) begin
        report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      end
      if (got.read_data !== want.read_data) begin
        report_mismatch($sformatf("read_data %h, expected %h",
                                  got.read_data, want.read_data));
      end
    end
  endtask

  // Offers one item, optionally after a short idle burst, and records the
  // expected result once the block has taken it.
  task automatic send_item(mqrb_pkg::in_item_t it);
    if (in_gap_odds != 0 && $urandom_range(1, in_gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(predict_result(it));
    items_sent++;
  endtask

  task automatic set_idling(bit on);
    if (on) begin
      in_gap_odds    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 5);
      out_stall_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 5);
    end else begin
      in_gap_odds    = 0;
      out_stall_odds = 0;
    end
  endtask

  function automatic mqrb_pkg::func_t random_func();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 9) return mqrb_pkg::OP_WRITE;
    if (sel < 17) return mqrb_pkg::OP_READ;
    if (sel < 18) return mqrb_pkg::OP_INIT;
    if (sel < 19) return mqrb_pkg::OP_RSVD;
    return mqrb_pkg::func_t'($urandom_range(0, 3));
  endfunction

  task automatic test_empty_reads();
    send_item(make_item(mqrb_pkg::OP_READ, 4'd0, 32'h0));
    send_item(make_item(mqrb_pkg::OP_READ, mqrb_pkg::QIDX_W'(NUM_Q - 1), 32'hFFFF_FFFF));
  endtask

  task automatic test_bad_index();
    send_item(make_item(mqrb_pkg::OP_INIT, mqrb_pkg::QIDX_W'(NUM_Q), 32'h0));
    send_item(make_item(mqrb_pkg::OP_READ, 4'd15, 32'hFFFF_FFFF));
    send_item(make_item(mqrb_pkg::OP_WRITE, 4'd15, 32'hFFFF_FFFF));
    send_item(make_item(mqrb_pkg::OP_WRITE, mqrb_pkg::QIDX_W'(NUM_Q), 32'h1234_5678));
  endtask

  task automatic test_unused_op();
    send_item(make_item(mqrb_pkg::OP_RSVD, 4'd15, 32'hFFFF_FFFF));
    send_item(make_item(mqrb_pkg::OP_RSVD, 4'd0, 32'h0));
  endtask

  task automatic test_data_extremes();
    send_item(make_item(mqrb_pkg::OP_WRITE, 4'd0, 32'h0000_0000));
    send_item(make_item(mqrb_pkg::OP_WRITE, 4'd0, 32'hFFFF_FFFF));
    send_item(make_item(mqrb_pkg::OP_WRITE, mqrb_pkg::QIDX_W'(NUM_Q - 1), 32'hA5A5_5A5A));
    send_item(make_item(mqrb_pkg::OP_READ, 4'd0, 32'h0));
    send_item(make_item(mqrb_pkg::OP_READ, 4'd0, 32'h0));
    send_item(make_item(mqrb_pkg::OP_READ, mqrb_pkg::QIDX_W'(NUM_Q - 1), 32'h0));
  endtask

  // Init must empty the queue and restart both pointers.
  task automatic test_init();
    send_item(make_item(mqrb_pkg::OP_WRITE, 4'd3, 32'hDEAD_0001));
    send_item(make_item(mqrb_pkg::OP_WRITE, 4'd3, 32'hDEAD_0002));
    send_item(make_item(mqrb_pkg::OP_INIT, 4'd3, 32'h0));
    send_item(make_item(mqrb_pkg::OP_READ, 4'd3, 32'h0));
    send_item(make_item(mqrb_pkg::OP_WRITE, 4'd3, 32'hBEEF_0003));
    send_item(make_item(mqrb_pkg::OP_READ, 4'd3, 32'h0));
  endtask

  // Partial drain to move the pointers, then fill past full and drain past
  // empty, so that both pointers wrap.
  task automatic test_fill_drain(int rounds);
    int                          q;
    int                          n;
    logic [mqrb_pkg::QIDX_W-1:0] qi;
    for (int r = 0; r < rounds; r++) begin
      set_idling(1);
      q  = $urandom_range(0, NUM_Q - 1);
      qi = mqrb_pkg::QIDX_W'(q);
      n  = $urandom_range(0, q_fill[q]);
      repeat (n) send_item(make_item(mqrb_pkg::OP_READ, qi, $urandom));
      while (q_fill[q] < DEPTH) send_item(make_item(mqrb_pkg::OP_WRITE, qi, $urandom));
      repeat ($urandom_range(1, 2)) send_item(make_item(mqrb_pkg::OP_WRITE, qi, $urandom));
      while (q_fill[q] != 0) send_item(make_item(mqrb_pkg::OP_READ, qi, $urandom));
      send_item(make_item(mqrb_pkg::OP_READ, qi, $urandom));
    end
  endtask

  task automatic test_random_mix(int count, bit idle_on);
    int                          stop_at;
    int                          focus;
    int                          kind;
    logic [mqrb_pkg::QIDX_W-1:0] fq;
    logic [mqrb_pkg::QIDX_W-1:0] q;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      set_idling(idle_on);
      focus = $urandom_range(0, NUM_Q - 1);
      fq    = mqrb_pkg::QIDX_W'(focus);
      kind  = $urandom_range(0, 9);
      if (kind < 2) begin
        while (q_fill[focus] < DEPTH) send_item(make_item(mqrb_pkg::OP_WRITE, fq, $urandom));
        send_item(make_item(mqrb_pkg::OP_WRITE, fq, $urandom));
      end else if (kind < 4) begin
        while (q_fill[focus] != 0) send_item(make_item(mqrb_pkg::OP_READ, fq, $urandom));
        send_item(make_item(mqrb_pkg::OP_READ, fq, $urandom));
      end else begin
        repeat ($urandom_range(4, 12)) begin
          if ($urandom_range(0, 11) == 0) begin
            q = mqrb_pkg::QIDX_W'($urandom_range(0, 15));
          end else if ($urandom_range(0, 3) == 0) begin
            q = mqrb_pkg::QIDX_W'($urandom_range(0, NUM_Q - 1));
          end else begin
            q = fq;
          end
          send_item(make_item(random_func(), q, $urandom));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result(out_item);
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (out_stall_odds != 0 && $urandom_range(1, out_stall_odds) == 1) begin
      stall_left = $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < NUM_Q; i++) begin
      q_head[i] = 0;
      q_tail[i] = 0;
      q_fill[i] = 0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_reads();
    test_bad_index();
    test_unused_op();
    test_data_extremes();
    test_init();
    test_fill_drain(5);
    test_random_mix(850, 1'b1);
    // The closing stretch runs flat out on both sides.
    test_random_mix(150, 1'b0);

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
